/* rtl/core/mips_execute_stage_alu_assert.svh */
// Assertion macros shared by the execute stage ALU.
`ifndef MIPS_EXECUTE_STAGE_ALU_ASSERT_SVH
`define MIPS_EXECUTE_STAGE_ALU_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MEA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("execute stage ALU assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("execute stage ALU assertion failed");

`endif

/* rtl/core/mea_pkg.sv */
// Shared types, opcodes and function codes of the execute stage ALU.
`timescale 1ns / 1ps
package mea_pkg;

  typedef logic [31:0] word_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam int unsigned MD_STEPS = 32;
  localparam int unsigned MD_CNT_W = $clog2(MD_STEPS);

  typedef enum logic [2:0] {
    WB_RD    = 3'd0,
    WB_RT    = 3'd1,
    WB_LOAD  = 3'd2,
    WB_STORE = 3'd3,
    WB_HALT  = 3'd4,
    WB_NONE  = 3'd5
  } wb_kind_e_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_e_t;

  typedef enum logic [1:0] {
    MD_MULT,
    MD_MULTU,
    MD_DIV,
    MD_DIVU
  } md_op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } top_state_e_t;

  typedef enum logic [1:0] {
    MDS_IDLE,
    MDS_STEP,
    MDS_FIX
  } md_state_e_t;

  typedef struct packed {
    word_t      result;
    wb_kind_e_t kind;
    logic [4:0] dest;
    word_t      store_data;
    size_e_t    size;
  } res_t;

  typedef struct packed {
    logic     md_start;
    md_op_e_t md_op;
    logic     wr_hi;
    logic     wr_lo;
  } alu_ctrl_t;

  typedef struct packed {
    logic     start;
    md_op_e_t op;
  } md_req_t;

  typedef struct packed {
    logic  done;
    word_t hi;
    word_t lo;
  } md_rsp_t;

endpackage

/* rtl/core/mea_alu.sv */
// Instruction decoder and combinational ALU of the execute stage.
`timescale 1ns / 1ps
module mea_alu import mea_pkg::*; (
  input  word_t     instruction,
  input  word_t     operand_a,
  input  word_t     operand_b,
  input  word_t     hi,
  input  word_t     lo,
  output res_t      res,
  output alu_ctrl_t ctrl
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [15:0] imm;
  word_t       simm;
  word_t       zimm;
  word_t       addr;

  assign op   = instruction[31:26];
  assign fn   = instruction[5:0];
  assign rt   = instruction[20:16];
  assign rd   = instruction[15:11];
  assign sa   = instruction[10:6];
  assign imm  = instruction[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};
  assign addr = operand_a + simm;

  always_comb begin
    res  = '{result: '0, kind: WB_NONE, dest: '0, store_data: '0, size: SZ_BYTE};
    ctrl = '{md_start: 1'b0, md_op: MD_MULT, wr_hi: 1'b0, wr_lo: 1'b0};
    if (instruction != '0) begin
      if (op == OP_SPECIAL) begin
        res.kind = WB_RD;
        unique case (fn)
          FN_ADD, FN_ADDU: res.result = operand_a + operand_b;
          FN_SUB, FN_SUBU: res.result = operand_a - operand_b;
          FN_AND:  res.result = operand_a & operand_b;
          FN_OR:   res.result = operand_a | operand_b;
          FN_XOR:  res.result = operand_a ^ operand_b;
          FN_NOR:  res.result = ~(operand_a | operand_b);
          FN_SLT:  res.result = {31'd0, $signed(operand_a) < $signed(operand_b)};
          FN_SLL:  res.result = operand_b << sa;
          FN_SRL:  res.result = operand_b >> sa;
          FN_SRA:  res.result = word_t'($signed(operand_b) >>> sa);
          FN_MFHI: res.result = hi;
          FN_MFLO: res.result = lo;
          FN_MTHI: begin
            ctrl.wr_hi = 1'b1;
            res.kind   = WB_NONE;
          end
          FN_MTLO: begin
            ctrl.wr_lo = 1'b1;
            res.kind   = WB_NONE;
          end
          FN_MULT: begin
            ctrl.md_start = 1'b1;
            ctrl.md_op    = MD_MULT;
            res.kind      = WB_NONE;
          end
          FN_MULTU: begin
            ctrl.md_start = 1'b1;
            ctrl.md_op    = MD_MULTU;
            res.kind      = WB_NONE;
          end
          FN_DIV: begin
            ctrl.md_start = (operand_b != '0);
            ctrl.md_op    = MD_DIV;
            res.kind      = WB_NONE;
          end
          FN_DIVU: begin
            ctrl.md_start = (operand_b != '0);
            ctrl.md_op    = MD_DIVU;
            res.kind      = WB_NONE;
          end
          FN_SYSCALL: res.kind = WB_HALT;
          default: res.kind = WB_NONE;
        endcase
        if (res.kind == WB_RD) begin
          res.dest = rd;
        end
      end else begin
        unique case (op)
          OP_ADDI, OP_ADDIU: begin
            res.result = addr;
            res.kind   = WB_RT;
          end
          OP_ANDI: begin
            res.result = operand_a & zimm;
            res.kind   = WB_RT;
          end
          OP_ORI: begin
            res.result = operand_a | zimm;
            res.kind   = WB_RT;
          end
          OP_XORI: begin
            res.result = operand_a ^ zimm;
            res.kind   = WB_RT;
          end
          OP_LUI: begin
            res.result = {imm, 16'h0000};
            res.kind   = WB_RT;
          end
          OP_LB, OP_LH, OP_LW: begin
            res.result = addr;
            res.kind   = WB_LOAD;
            res.dest   = rt;
            res.size   = (op == OP_LB) ? SZ_BYTE : ((op == OP_LH) ? SZ_HALF : SZ_WORD);
          end
          OP_SB, OP_SH, OP_SW: begin
            res.result     = addr;
            res.kind       = WB_STORE;
            res.store_data = operand_b;
            res.size       = (op == OP_SB) ? SZ_BYTE : ((op == OP_SH) ? SZ_HALF : SZ_WORD);
          end
          default: res.kind = WB_NONE;
        endcase
        if (res.kind == WB_RT) begin
          res.dest = rt;
        end
      end
    end
  end

endmodule

/* rtl/core/mea_muldiv.sv */
// Iterative multiply and divide unit built around one shared 34-bit adder.
`timescale 1ns / 1ps
module mea_muldiv import mea_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  input  word_t   operand_a,
  input  word_t   operand_b,
  output md_rsp_t rsp
);

  md_state_e_t         state_r, state_nxt;
  logic [MD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  word_t               hi_r, hi_nxt;
  word_t               lo_r, lo_nxt;
  word_t               mcand_r, mcand_nxt;
  logic                is_mul_r, is_mul_nxt;
  logic                neg_hi_r, neg_hi_nxt;
  logic                neg_lo_r, neg_lo_nxt;

  logic                is_signed;
  logic                sign_a;
  logic                sign_b;
  word_t               mag_a;
  word_t               mag_b;
  logic [33:0]         add_x;
  logic [33:0]         add_y;
  logic                add_sub;
  logic [33:0]         add_sum;
  logic [32:0]         mul_t;
  logic [63:0]         prod_neg;

  assign is_signed = (req.op == MD_MULT) || (req.op == MD_DIV);
  assign sign_a    = is_signed && operand_a[31];
  assign sign_b    = is_signed && operand_b[31];
  assign mag_a     = sign_a ? (word_t'(0) - operand_a) : operand_a;
  assign mag_b     = sign_b ? (word_t'(0) - operand_b) : operand_b;

  assign add_x   = is_mul_r ? {2'b00, hi_r} : {1'b0, hi_r, lo_r[31]};
  assign add_y   = {2'b00, mcand_r};
  assign add_sub = !is_mul_r;
  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};

  assign mul_t    = lo_r[0] ? add_sum[32:0] : {1'b0, hi_r};
  assign prod_neg = 64'd0 - {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MDS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    mcand_r  <= mcand_nxt;
    is_mul_r <= is_mul_nxt;
    neg_hi_r <= neg_hi_nxt;
    neg_lo_r <= neg_lo_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    mcand_nxt  = mcand_r;
    is_mul_nxt = is_mul_r;
    neg_hi_nxt = neg_hi_r;
    neg_lo_nxt = neg_lo_r;
    unique case (state_r)
      MDS_IDLE: begin
        if (req.start) begin
          state_nxt  = MDS_STEP;
          cnt_nxt    = '0;
          hi_nxt     = '0;
          lo_nxt     = mag_a;
          mcand_nxt  = mag_b;
          is_mul_nxt = (req.op == MD_MULT) || (req.op == MD_MULTU);
          if ((req.op == MD_MULT) || (req.op == MD_MULTU)) begin
            neg_hi_nxt = sign_a ^ sign_b;
            neg_lo_nxt = 1'b0;
          end else begin
            neg_hi_nxt = sign_a;
            neg_lo_nxt = sign_a ^ sign_b;
          end
        end
      end
      MDS_STEP: begin
        if (is_mul_r) begin
          hi_nxt = mul_t[32:1];
          lo_nxt = {mul_t[0], lo_r[31:1]};
        end else if (!add_sum[33]) begin
          hi_nxt = add_sum[31:0];
          lo_nxt = {lo_r[30:0], 1'b1};
        end else begin
          hi_nxt = add_x[31:0];
          lo_nxt = {lo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MD_CNT_W'(MD_STEPS - 1)) begin
          state_nxt = MDS_FIX;
        end
      end
      MDS_FIX: begin
        if (is_mul_r) begin
          if (neg_hi_r) begin
            hi_nxt = prod_neg[63:32];
            lo_nxt = prod_neg[31:0];
          end
        end else begin
          if (neg_hi_r) begin
            hi_nxt = word_t'(0) - hi_r;
          end
          if (neg_lo_r) begin
            lo_nxt = word_t'(0) - lo_r;
          end
        end
        done_nxt  = 1'b1;
        state_nxt = MDS_IDLE;
      end
      default: state_nxt = MDS_IDLE;
    endcase
  end

  assign rsp = '{done: done_r, hi: hi_r, lo: lo_r};

endmodule

/* rtl/core/mips_execute_stage_alu.sv */
// MIPS32 execute stage: an ALU result is registered into the result register at its transfer,
// or waits in a pending register while the output stalls; MULT, MULTU, and DIV and DIVU
// with a nonzero divisor load the multiply/divide unit at their transfer, then run 32
// steps of its shared add/subtract unit, one sign fix-up step and a registered finished
// flag before one of them reaches the result register; the next instruction can enter
// once it is loaded. A divide by zero takes the ALU result path and leaves HI and LO unchanged.
// The stage accepts no instruction while a multiply or divide runs or while a
// second finished result waits behind a stalled output register.
`timescale 1ns / 1ps
module mips_execute_stage_alu import mea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic [2:0]  out_writeback_kind,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_store_data,
  output logic [1:0]  out_access_size
);

  top_state_e_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  res_t         out_data_r, out_data_nxt;
  res_t         pend_r;
  word_t        hi_r, hi_nxt;
  word_t        lo_r, lo_nxt;

  logic         in_accept;
  logic         out_free;
  logic         out_load;
  logic         out_from_pend;
  res_t         alu_res;
  alu_ctrl_t    alu_ctrl;
  md_req_t      md_req;
  md_rsp_t      md_rsp;

  mea_alu u_alu (
    .instruction (in_instruction),
    .operand_a   (in_operand_a),
    .operand_b   (in_operand_b),
    .hi          (hi_r),
    .lo          (lo_r),
    .res         (alu_res),
    .ctrl        (alu_ctrl)
  );

  mea_muldiv u_muldiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (md_req),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .rsp       (md_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign md_req    = '{start: in_accept && alu_ctrl.md_start, op: alu_ctrl.md_op};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hi_r        <= '0;
      lo_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_accept) begin
      pend_r <= alu_res;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_from_pend = 1'b0;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (alu_ctrl.wr_hi) begin
            hi_nxt = in_operand_a;
          end
          if (alu_ctrl.wr_lo) begin
            lo_nxt = in_operand_a;
          end
          if (alu_ctrl.md_start) begin
            state_nxt = ST_RUN;
          end else if (out_free) begin
            out_load = 1'b1;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_RUN: begin
        if (md_rsp.done) begin
          hi_nxt = md_rsp.hi;
          lo_nxt = md_rsp.lo;
          if (out_free) begin
            out_load      = 1'b1;
            out_from_pend = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_from_pend = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_data_nxt = out_from_pend ? pend_r : alu_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_data_r.result;
  assign out_writeback_kind = out_data_r.kind;
  assign out_dest_reg       = out_data_r.dest;
  assign out_store_data     = out_data_r.store_data;
  assign out_access_size    = out_data_r.size;

`include "mips_execute_stage_alu_assert.svh"

  `MEA_ASSERT_SAME(a_done_only_in_run, md_rsp.done, state_r == ST_RUN)
  `MEA_ASSERT_NEXT(a_start_enters_run, md_req.start, state_r == ST_RUN)
  `MEA_ASSERT_SAME(a_hold_has_output, state_r == ST_HOLD, out_valid_r)

endmodule
